// ----- rtl/assert_macros.svh -----
// assertion macros shared by the channel shaper rtl
// no dependencies; expects clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rces assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rces assertion failed");

`endif

// ----- rtl/rces_pkg.sv -----
// constants, register map and shared types of the channel shaper
// no dependencies
package rces_pkg;

  localparam int GAIN_FRAC = 12;
  localparam int EXPO_FRAC = 14;
  localparam int G_FRAC    = 20;
  localparam int SER_FRAC  = 28;
  localparam int EXPO_ONE  = 16384;
  localparam int G_W       = 25;
  localparam int CFG_AW    = 5;
  localparam int REG_W     = 3;

  localparam longint E_Q28 = 64'sd729683222;

  localparam logic [REG_W-1:0] REG_SCALE_GAIN      = 3'd0;
  localparam logic [REG_W-1:0] REG_CALIB_OFFSET    = 3'd1;
  localparam logic [REG_W-1:0] REG_INVERT_POLARITY = 3'd2;
  localparam logic [REG_W-1:0] REG_TRIM_OFFSET     = 3'd3;
  localparam logic [REG_W-1:0] REG_RATE_GAIN       = 3'd4;
  localparam logic [REG_W-1:0] REG_EXPO_AMOUNT     = 3'd5;
  localparam logic [REG_W-1:0] REG_CURVE_MODE      = 3'd6;
  localparam logic [REG_W-1:0] REG_MIXER_ENABLE    = 3'd7;

  localparam logic [1:0] CURVE_SIGNED = 2'd0;
  localparam int CURVE_CLAMP_BIT = 1;

  typedef logic [G_W-1:0] g_word_t;

endpackage

// ----- rtl/rces_exp_rom.sv -----
// exponential curve rom, split into even and odd banks with registered reads
// depends on rces_pkg; table contents computed at elaboration
module rces_exp_rom #(
  parameter int DEPTH = 256
) (
  input  logic                         clk,
  input  logic [$clog2(DEPTH+1)-1:0]   rd_idx,
  input  logic                         rd_over,
  output rces_pkg::g_word_t            g_lo,
  output rces_pkg::g_word_t            g_hi
);
  import rces_pkg::*;

  localparam int AW     = $clog2(DEPTH+1);
  localparam int EVEN_N = DEPTH/2 + 1;
  localparam int ODD_N  = (DEPTH+1)/2;
  localparam int EA_W   = $clog2(EVEN_N);
  localparam int OA_W   = $clog2(ODD_N);
  localparam longint SER_ONE = 64'sd1 <<< SER_FRAC;
  localparam longint Z_DIV   = 8 * DEPTH;

  typedef g_word_t even_tab_t [EVEN_N];
  typedef g_word_t odd_tab_t  [ODD_N];

  function automatic g_word_t exp_point(input longint k);
    longint z;
    longint sum;
    longint term;
    z = (E_Q28 * (2*k - DEPTH)) / Z_DIV;
    sum  = SER_ONE;
    term = SER_ONE;
    term = (term * z) / (SER_ONE * 1);  sum += term;
    term = (term * z) / (SER_ONE * 2);  sum += term;
    term = (term * z) / (SER_ONE * 3);  sum += term;
    term = (term * z) / (SER_ONE * 4);  sum += term;
    term = (term * z) / (SER_ONE * 5);  sum += term;
    term = (term * z) / (SER_ONE * 6);  sum += term;
    term = (term * z) / (SER_ONE * 7);  sum += term;
    term = (term * z) / (SER_ONE * 8);  sum += term;
    term = (term * z) / (SER_ONE * 9);  sum += term;
    term = (term * z) / (SER_ONE * 10); sum += term;
    for (int i = 0; i < 3; i++) begin
      sum = (sum * sum) >>> SER_FRAC;
    end
    return g_word_t'((sum + (64'sd1 <<< (SER_FRAC-G_FRAC-1))) >>> (SER_FRAC-G_FRAC));
  endfunction

  function automatic even_tab_t build_even();
    even_tab_t t;
    for (int j = 0; j < EVEN_N; j++) begin
      t[j] = exp_point(longint'(2*j));
    end
    return t;
  endfunction

  function automatic odd_tab_t build_odd();
    odd_tab_t t;
    for (int j = 0; j < ODD_N; j++) begin
      t[j] = exp_point(longint'(2*j + 1));
    end
    return t;
  endfunction

  localparam even_tab_t EVEN_ROM = build_even();
  localparam odd_tab_t  ODD_ROM  = build_odd();
  localparam g_word_t   LAST_G   = exp_point(longint'(DEPTH));

  logic            odd_sel;
  logic [AW-1:0]   half_idx;
  logic [AW-1:0]   even_sum;
  logic [EA_W-1:0] even_addr;
  logic [OA_W-1:0] odd_addr;
  g_word_t         even_word;
  g_word_t         odd_word;
  g_word_t         g_lo_r;
  g_word_t         g_hi_r;

  assign odd_sel   = rd_idx[0];
  assign half_idx  = rd_idx >> 1;
  assign even_sum  = half_idx + AW'(odd_sel);
  assign even_addr = rd_over ? '0 : even_sum[EA_W-1:0];
  assign odd_addr  = rd_over ? '0 : half_idx[OA_W-1:0];
  assign even_word = EVEN_ROM[even_addr];
  assign odd_word  = ODD_ROM[odd_addr];

  always_ff @(posedge clk) begin
    if (rd_over) begin
      g_lo_r <= LAST_G;
      g_hi_r <= LAST_G;
    end else if (odd_sel) begin
      g_lo_r <= odd_word;
      g_hi_r <= even_word;
    end else begin
      g_lo_r <= even_word;
      g_hi_r <= odd_word;
    end
  end

  assign g_lo = g_lo_r;
  assign g_hi = g_hi_r;

endmodule

// ----- rtl/rc_channel_expo_rate_shaper.sv -----
// channel shaper top level: calibration, trim, rate and expo curve pipeline
// depends on rces_pkg, rces_exp_rom and assert_macros.svh
//
//  channel  | ports                                             | handshake
//  ---------+---------------------------------------------------+----------------------------
//  input    | start, busy, in_raw_sample                        | start high, busy low
//  result   | out_strobe, out_channel_value, out_saturated_flag | one-cycle strobe
//  config   | psel, penable, pwrite, paddr, pwdata              | apb write, pready tied high
//
// one transaction per clock
// ten register stages around the rom read and the multiplies
// synchronous reset clears valid bits and configuration registers; busy is high only in reset
// results are never held back, so the pipeline never stalls
`include "assert_macros.svh"

module rc_channel_expo_rate_shaper #(
  parameter int EXP_TABLE_DEPTH = 256,
  parameter int FRAC_BITS       = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [15:0]           in_raw_sample,
  output logic                         out_strobe,
  output logic signed [15:0]           out_channel_value,
  output logic                         out_saturated_flag,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rces_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import rces_pkg::*;

  localparam int AW    = $clog2(EXP_TABLE_DEPTH+1);
  localparam int POS_W = 16 + AW;
  localparam int FR_W  = FRAC_BITS + 1;
  localparam int HALF  = 1 << (FRAC_BITS-1);
  localparam int ONE   = 1 << FRAC_BITS;
  localparam int X_W   = 25;
  localparam int DIF_W = G_W + 1;
  localparam int P6_W  = DIF_W + FR_W + 1;
  localparam int P7_W  = 16 + DIF_W;
  localparam int F_W   = 27;
  localparam int P8_W  = 16 + F_W;
  localparam int Y_W   = 23;
  localparam int P9_W  = 16 + Y_W;
  localparam int V_W   = 28;
  localparam int D_W   = V_W + 7;

  localparam logic signed [X_W-1:0] X_MAX    = X_W'(32767);
  localparam logic signed [X_W-1:0] X_MIN    = -X_MAX - X_W'(1);
  localparam logic signed [X_W-1:0] X_HALF   = X_W'(HALF);
  localparam logic signed [V_W-1:0] V_MAX    = V_W'(32767);
  localparam logic signed [V_W-1:0] V_MIN    = -V_MAX - V_W'(1);
  localparam logic signed [V_W-1:0] V_ONE    = V_W'(ONE);
  localparam logic signed [D_W-1:0] HUNDRED  = D_W'(100);
  localparam logic signed [D_W-1:0] DEAD_LIM = D_W'(5 * ONE);
  localparam logic signed [DIF_W-1:0] G_ONE  = DIF_W'(1 << G_FRAC);
  localparam logic signed [F_W-1:0]   F_ONE  = F_W'(1 << G_FRAC);

  // configuration registers
  logic signed [15:0] scale_gain_r;
  logic signed [15:0] calib_offset_r;
  logic               invert_polarity_r;
  logic signed [15:0] trim_offset_r;
  logic signed [15:0] rate_gain_r;
  logic [14:0]        expo_amount_r;
  logic [1:0]         curve_mode_r;
  logic               mixer_enable_r;

  logic             cfg_wr;
  logic [REG_W-1:0] reg_sel;
  logic             accept;
  logic             unsig;
  logic             clamp;

  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[CFG_AW-1:2];
  assign pready  = 1'b1;
  assign busy    = ~rst_n;
  assign accept  = start && !busy;
  assign unsig   = curve_mode_r != CURVE_SIGNED;
  assign clamp   = curve_mode_r[CURVE_CLAMP_BIT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_gain_r      <= 16'sd4096;
      calib_offset_r    <= '0;
      invert_polarity_r <= 1'b0;
      trim_offset_r     <= '0;
      rate_gain_r       <= 16'sd4096;
      expo_amount_r     <= '0;
      curve_mode_r      <= CURVE_SIGNED;
      mixer_enable_r    <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_SCALE_GAIN:      scale_gain_r      <= pwdata[15:0];
        REG_CALIB_OFFSET:    calib_offset_r    <= pwdata[15:0];
        REG_INVERT_POLARITY: invert_polarity_r <= pwdata[0];
        REG_TRIM_OFFSET:     trim_offset_r     <= pwdata[15:0];
        REG_RATE_GAIN:       rate_gain_r       <= pwdata[15:0];
        REG_EXPO_AMOUNT:     expo_amount_r     <= pwdata[14:0];
        REG_CURVE_MODE:      curve_mode_r      <= pwdata[1:0];
        REG_MIXER_ENABLE:    mixer_enable_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SCALE_GAIN:      prdata = {{16{scale_gain_r[15]}}, scale_gain_r};
      REG_CALIB_OFFSET:    prdata = {{16{calib_offset_r[15]}}, calib_offset_r};
      REG_INVERT_POLARITY: prdata = {31'd0, invert_polarity_r};
      REG_TRIM_OFFSET:     prdata = {{16{trim_offset_r[15]}}, trim_offset_r};
      REG_RATE_GAIN:       prdata = {{16{rate_gain_r[15]}}, rate_gain_r};
      REG_EXPO_AMOUNT:     prdata = {17'd0, expo_amount_r};
      REG_CURVE_MODE:      prdata = {30'd0, curve_mode_r};
      REG_MIXER_ENABLE:    prdata = {31'd0, mixer_enable_r};
      default:             prdata = '0;
    endcase
  end

  // valid bits, one per stage
  logic [9:1] vld_r;
  logic       out_strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= {vld_r[8:1], accept};
      out_strobe_r <= vld_r[9];
    end
  end

  // stage 1: calibration gain
  logic signed [31:0] prod1_nxt;
  logic signed [31:0] prod1_r;

  assign prod1_nxt = 32'(in_raw_sample) * 32'(scale_gain_r);

  // stage 2: offset and polarity
  logic signed [20:0] cal2;
  logic signed [21:0] cal2_x;
  logic signed [21:0] c2_nxt;
  logic signed [21:0] c2_r;

  assign cal2   = {prod1_r[31], prod1_r[31:GAIN_FRAC]} +
                  {{5{calib_offset_r[15]}}, calib_offset_r};
  assign cal2_x = {cal2[20], cal2};
  assign c2_nxt = invert_polarity_r ? -cal2_x : cal2_x;

  // stage 3: curve input and bypass value
  logic signed [X_W-1:0] c25;
  logic signed [X_W-1:0] trim25;
  logic signed [X_W-1:0] xsum3;
  logic signed [X_W-1:0] byp3_nxt;
  logic signed [15:0]    x3_nxt;
  logic                  flag3_nxt;

  assign c25      = {{(X_W-22){c2_r[21]}}, c2_r};
  assign trim25   = {{(X_W-16){trim_offset_r[15]}}, trim_offset_r};
  assign xsum3    = unsig ? c25 + X_HALF + trim25 : (c25 <<< 1) + trim25;
  assign byp3_nxt = unsig ? c25 + X_HALF : c25;

  always_comb begin
    flag3_nxt = 1'b0;
    x3_nxt    = xsum3[15:0];
    if (xsum3 > X_MAX) begin
      flag3_nxt = 1'b1;
      x3_nxt    = 16'sh7fff;
    end else if (xsum3 < X_MIN) begin
      flag3_nxt = 1'b1;
      x3_nxt    = 16'sh8000;
    end
  end

  // delay lines for values needed further down
  logic signed [15:0]    x_r    [3:7];
  logic                  flag_r [3:9];
  logic signed [X_W-1:0] byp_r  [3:9];
  logic [FR_W-1:0]       fr_r   [4:5];

  // stage 4: table position
  logic [15:0]      ax4;
  logic [POS_W-1:0] pos4;
  logic [POS_W-1:0] idxf4;
  logic [AW-1:0]    idx4_r;
  logic             over4_r;

  assign ax4   = x_r[3][15] ? 16'(-x_r[3]) : 16'(x_r[3]);
  assign pos4  = POS_W'(ax4) * POS_W'(EXP_TABLE_DEPTH);
  assign idxf4 = pos4 >> FR_W;

  // stage 5: table read
  g_word_t g_lo;
  g_word_t g_hi;

  rces_exp_rom #(
    .DEPTH (EXP_TABLE_DEPTH)
  ) u_rom (
    .clk     (clk),
    .rd_idx  (idx4_r),
    .rd_over (over4_r),
    .g_lo    (g_lo),
    .g_hi    (g_hi)
  );

  // stage 6: interpolation
  logic signed [DIF_W-1:0] glo_s;
  logic signed [DIF_W-1:0] diff6;
  logic signed [FR_W:0]    frs6;
  logic signed [P6_W-1:0]  prod6;
  logic signed [P6_W-1:0]  sh6;
  logic signed [DIF_W-1:0] g6_nxt;
  logic signed [DIF_W-1:0] g6_r;

  assign glo_s  = {1'b0, g_lo};
  assign diff6  = {1'b0, g_hi} - glo_s;
  assign frs6   = {1'b0, fr_r[5]};
  assign prod6  = P6_W'(diff6) * P6_W'(frs6);
  assign sh6    = prod6 >>> FR_W;
  assign g6_nxt = glo_s + sh6[DIF_W-1:0];

  // stage 7: expo blend factor
  logic [14:0]             p7;
  logic signed [15:0]      ps7;
  logic signed [DIF_W-1:0] gm7;
  logic signed [P7_W-1:0]  prod7;
  logic signed [P7_W-1:0]  sh7;
  logic signed [F_W-1:0]   f7_nxt;
  logic signed [F_W-1:0]   f7_r;

  assign p7     = (expo_amount_r > 15'(EXPO_ONE)) ? 15'(EXPO_ONE) : expo_amount_r;
  assign ps7    = {1'b0, p7};
  assign gm7    = g6_r - G_ONE;
  assign prod7  = P7_W'(ps7) * P7_W'(gm7);
  assign sh7    = prod7 >>> EXPO_FRAC;
  assign f7_nxt = F_ONE + sh7[F_W-1:0];

  // stage 8: curve value
  logic signed [P8_W-1:0] prod8;
  logic signed [P8_W-1:0] sh8;
  logic signed [Y_W-1:0]  y8_nxt;
  logic signed [Y_W-1:0]  y8_r;

  assign prod8  = P8_W'(x_r[7]) * P8_W'(f7_r);
  assign sh8    = prod8 >>> G_FRAC;
  assign y8_nxt = sh8[Y_W-1:0];

  // stage 9: rate
  logic signed [P9_W-1:0] prod9_nxt;
  logic signed [P9_W-1:0] prod9_r;

  assign prod9_nxt = P9_W'(rate_gain_r) * P9_W'(y8_r);

  // stage 10: scaling, bypass, clamp and saturation
  logic signed [P9_W-1:0] sh10;
  logic signed [V_W-1:0]  v10;
  logic signed [V_W-1:0]  vc10;
  logic signed [D_W-1:0]  v100;
  logic signed [15:0]     out_nxt;
  logic                   sat10;
  logic                   flag10_nxt;
  logic signed [15:0]     out_channel_value_r;
  logic                   out_saturated_flag_r;

  assign sh10 = unsig ? (prod9_r >>> GAIN_FRAC) : (prod9_r >>> (GAIN_FRAC+1));
  assign v10  = mixer_enable_r ? sh10[V_W-1:0] : V_W'(byp_r[9]);
  assign v100 = D_W'(v10) * HUNDRED;

  always_comb begin
    vc10 = v10;
    if (clamp) begin
      if (v10 > V_ONE) begin
        vc10 = V_ONE;
      end else if (v100 < DEAD_LIM) begin
        vc10 = '0;
      end
    end
  end

  always_comb begin
    sat10   = 1'b0;
    out_nxt = vc10[15:0];
    if (vc10 > V_MAX) begin
      sat10   = 1'b1;
      out_nxt = 16'sh7fff;
    end else if (vc10 < V_MIN) begin
      sat10   = 1'b1;
      out_nxt = 16'sh8000;
    end
  end

  assign flag10_nxt = (flag_r[9] && mixer_enable_r) || sat10;

  // datapath registers
  always_ff @(posedge clk) begin
    prod1_r   <= prod1_nxt;
    c2_r      <= c2_nxt;
    x_r[3]    <= x3_nxt;
    flag_r[3] <= flag3_nxt;
    byp_r[3]  <= byp3_nxt;
    for (int s = 4; s <= 7; s++) begin
      x_r[s] <= x_r[s-1];
    end
    for (int s = 4; s <= 9; s++) begin
      flag_r[s] <= flag_r[s-1];
      byp_r[s]  <= byp_r[s-1];
    end
    idx4_r               <= idxf4[AW-1:0];
    over4_r              <= idxf4 >= POS_W'(EXP_TABLE_DEPTH);
    fr_r[4]              <= pos4[FR_W-1:0];
    fr_r[5]              <= fr_r[4];
    g6_r                 <= g6_nxt;
    f7_r                 <= f7_nxt;
    y8_r                 <= y8_nxt;
    prod9_r              <= prod9_nxt;
    out_channel_value_r  <= out_nxt;
    out_saturated_flag_r <= flag10_nxt;
  end

  assign out_strobe         = out_strobe_r;
  assign out_channel_value  = out_channel_value_r;
  assign out_saturated_flag = out_saturated_flag_r;

  `ASSERT_IMPL(a_latency, out_strobe_r, $past(start && !busy, 10))
  `ASSERT_NEXT(a_rom_last, vld_r[4] && over4_r, g_lo == g_hi)
  `ASSERT_IMPL(a_bypass_flag, out_strobe_r && out_saturated_flag_r && !mixer_enable_r,
               out_channel_value_r == 16'sh7fff || out_channel_value_r == 16'sh8000)
  `ASSERT_IMPL(a_clamp_range, out_strobe_r && clamp && !mixer_enable_r,
               !out_saturated_flag_r && !out_channel_value_r[15])

endmodule

// ----- bench/tb_rc_channel_expo_rate_shaper.sv -----
// self-checking testbench for the channel shaper: calibration, trim, rate and expo curve
// drives samples and apb register writes, predicts each shaped value in a scoreboard
// depends on rces_pkg and rc_channel_expo_rate_shaper
module tb_rc_channel_expo_rate_shaper;
  timeunit 1ns;
  timeprecision 1ps;

  import rces_pkg::*;

  localparam int DEPTH      = 256;
  localparam int FRAC_BITS  = 14;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_WAIT  = 20;
  localparam longint ONE_Q  = longint'(1) << FRAC_BITS;
  localparam longint HALF_Q = longint'(1) << (FRAC_BITS - 1);

  localparam logic [1:0] CURVE_UNSIGNED   = 2'd1;
  localparam logic [1:0] CURVE_CLAMPED    = 2'd2;
  localparam logic [1:0] CURVE_CLAMPED_HI = 2'd3;

  typedef struct packed {
    logic signed [15:0] value;
    logic               flag;
  } shaped_t;

  typedef struct packed {
    logic signed [15:0] scale_gain;
    logic signed [15:0] calib_offset;
    logic               invert;
    logic signed [15:0] trim_offset;
    logic signed [15:0] rate_gain;
    logic [14:0]        expo;
    logic [1:0]         mode;
    logic               mix_en;
  } shaper_cfg_t;

  localparam shaper_cfg_t CFG_RESET = '{
    scale_gain: 16'sd4096, calib_offset: 16'sd0, invert: 1'b0, trim_offset: 16'sd0,
    rate_gain: 16'sd4096, expo: 15'd0, mode: CURVE_SIGNED, mix_en: 1'b1
  };

  class shaper_scoreboard;
    shaped_t pending[$];
    int      errors;

    function new();
      errors = 0;
    endfunction

    function void note(shaped_t expected);
      pending.push_back(expected);
    endfunction

    function void check(logic signed [15:0] value, logic flag);
      shaped_t exp_res;
      if (pending.size() == 0) begin
        $error("channel_value %0d arrived with no transaction waiting", value);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (value !== exp_res.value) begin
        $error("channel_value expected %0d actual %0d", exp_res.value, value);
        errors++;
      end
      if (flag !== exp_res.flag) begin
        $error("saturated_flag expected %0b actual %0b", exp_res.flag, flag);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [15:0]   in_raw_sample = '0;
  logic                 out_strobe;
  logic signed [15:0]   out_channel_value;
  logic                 out_saturated_flag;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [CFG_AW-1:0]    paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  shaper_scoreboard sb = new();
  shaper_cfg_t      cfg = CFG_RESET;
  longint           exp_table[0:DEPTH];
  int               idle_cycles = 0;

  rc_channel_expo_rate_shaper #(
    .EXP_TABLE_DEPTH(DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_raw_sample(in_raw_sample),
    .out_strobe(out_strobe),
    .out_channel_value(out_channel_value),
    .out_saturated_flag(out_saturated_flag),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // g(u) table: series exp of z, squared three times, rounded to q.20
  initial begin : build_exp_table
    longint z;
    longint sum;
    longint term;
    for (int k = 0; k <= DEPTH; k++) begin
      z = (E_Q28 * longint'(2 * k - DEPTH)) / longint'(8 * DEPTH);
      sum = longint'(1) << SER_FRAC;
      term = sum;
      for (int n = 1; n <= 10; n++) begin
        term = (term * z) / (longint'(n) << SER_FRAC);
        sum += term;
      end
      repeat (3) sum = (sum * sum) >>> SER_FRAC;
      exp_table[k] = (sum + (longint'(1) << (SER_FRAC - G_FRAC - 1))) >>> (SER_FRAC - G_FRAC);
    end
  end

  function automatic shaped_t shape_channel(logic signed [15:0] raw);
    longint  c, x, ax, pos, idx, fr, g, p, f, y, v;
    bit      unsig, clamp, flag;
    shaped_t res;
    unsig = cfg.mode != CURVE_SIGNED;
    clamp = cfg.mode[CURVE_CLAMP_BIT];
    flag = 1'b0;
    c = ((longint'(raw) * longint'(cfg.scale_gain)) >>> GAIN_FRAC) + longint'(cfg.calib_offset);
    if (cfg.invert) c = -c;
    if (!cfg.mix_en) begin
      v = unsig ? c + HALF_Q : c;
    end else begin
      x = unsig ? c + HALF_Q + longint'(cfg.trim_offset) : 2 * c + longint'(cfg.trim_offset);
      if (x > 32767) begin
        x = 32767;
        flag = 1'b1;
      end else if (x < -32768) begin
        x = -32768;
        flag = 1'b1;
      end
      ax = (x < 0) ? -x : x;
      pos = ax * DEPTH;
      idx = pos >> (FRAC_BITS + 1);
      fr = pos & ((longint'(1) << (FRAC_BITS + 1)) - 1);
      if (idx >= DEPTH) begin
        g = exp_table[DEPTH];
      end else begin
        g = exp_table[idx] + (((exp_table[idx + 1] - exp_table[idx]) * fr) >>> (FRAC_BITS + 1));
      end
      p = (cfg.expo > EXPO_ONE) ? longint'(EXPO_ONE) : longint'(cfg.expo);
      f = (longint'(1) << G_FRAC) + ((p * (g - (longint'(1) << G_FRAC))) >>> EXPO_FRAC);
      y = (x * f) >>> G_FRAC;
      v = (longint'(cfg.rate_gain) * y) >>> (unsig ? GAIN_FRAC : GAIN_FRAC + 1);
    end
    if (clamp) begin
      if (v > ONE_Q) v = ONE_Q;
      else if (v * 100 < 5 * ONE_Q) v = 0;
    end
    if (v > 32767) begin
      v = 32767;
      flag = 1'b1;
    end else if (v < -32768) begin
      v = -32768;
      flag = 1'b1;
    end
    res.value = 16'(v);
    res.flag = flag;
    return res;
  endfunction

  function automatic logic [15:0] pick_word(int lo, int hi);
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom);
      default: return 16'(lo + int'($urandom_range(0, hi - lo)));
    endcase
  endfunction

  function automatic shaper_cfg_t pick_config();
    shaper_cfg_t c;
    c.scale_gain = pick_word(2048, 8192);
    c.calib_offset = pick_word(-4096, 4096);
    c.invert = 1'($urandom_range(0, 1));
    c.trim_offset = pick_word(-4096, 4096);
    c.rate_gain = pick_word(-8192, 8192);
    case ($urandom_range(0, 5))
      0: c.expo = 15'd0;
      1: c.expo = 15'(EXPO_ONE);
      2: c.expo = 15'h7fff;
      default: c.expo = 15'($urandom_range(0, EXPO_ONE));
    endcase
    c.mode = 2'($urandom_range(0, 3));
    c.mix_en = ($urandom_range(0, 4) != 0);
    return c;
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2, 3: return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic write_reg(logic [REG_W-1:0] idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SCALE_GAIN:      cfg.scale_gain = data[15:0];
      REG_CALIB_OFFSET:    cfg.calib_offset = data[15:0];
      REG_INVERT_POLARITY: cfg.invert = data[0];
      REG_TRIM_OFFSET:     cfg.trim_offset = data[15:0];
      REG_RATE_GAIN:       cfg.rate_gain = data[15:0];
      REG_EXPO_AMOUNT:     cfg.expo = data[14:0];
      REG_CURVE_MODE:      cfg.mode = data[1:0];
      REG_MIXER_ENABLE:    cfg.mix_en = data[0];
      default: ;
    endcase
  endtask

  task automatic load_config(shaper_cfg_t c);
    write_reg(REG_SCALE_GAIN, 32'(c.scale_gain));
    write_reg(REG_CALIB_OFFSET, 32'(c.calib_offset));
    write_reg(REG_INVERT_POLARITY, 32'(c.invert));
    write_reg(REG_TRIM_OFFSET, 32'(c.trim_offset));
    write_reg(REG_RATE_GAIN, 32'(c.rate_gain));
    write_reg(REG_EXPO_AMOUNT, 32'(c.expo));
    write_reg(REG_CURVE_MODE, 32'(c.mode));
    write_reg(REG_MIXER_ENABLE, 32'(c.mix_en));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_sample(logic signed [15:0] v);
    start <= 1'b1;
    in_raw_sample <= v;
    do @(posedge clk); while (busy);
    sb.note(shape_channel(v));
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    in_raw_sample <= 16'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int count, bit gaps);
    for (int i = 0; i < count; i++) begin
      if (gaps && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 6));
      send_sample(pick_sample());
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check(out_channel_value, out_saturated_flag);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    shaper_cfg_t        c;
    logic signed [15:0] reset_pts[$];
    logic signed [15:0] expo_pts[$];
    logic signed [15:0] bypass_pts[$];
    logic signed [15:0] sat_pts[$];
    reset_pts = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1, 16'sd1, 16'sd16384, -16'sd16384,
                  16'sd8191, 16'sh5555, 16'shaaaa};
    expo_pts = '{16'sd0, 16'sd4000, 16'sd8000, 16'sd16384, 16'sh8000};
    // dead zone edges sit at 819 and 820 after the offset, inversion and half-scale shift
    bypass_pts = '{16'sd15565, 16'sd15564, 16'sh8000, 16'sh7fff};
    sat_pts = '{16'sh7fff, 16'sh8000, 16'sd100, -16'sd100};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, signed curve without expo
    foreach (reset_pts[i]) send_sample(reset_pts[i]);

    drain_results();
    c = CFG_RESET;
    c.expo = 15'h7fff;
    c.mode = CURVE_CLAMPED_HI;
    load_config(c);
    foreach (expo_pts[i]) send_sample(expo_pts[i]);

    drain_results();
    c = CFG_RESET;
    c.mode = CURVE_CLAMPED;
    c.mix_en = 1'b0;
    c.invert = 1'b1;
    c.calib_offset = -16'sd8192;
    load_config(c);
    foreach (bypass_pts[i]) send_sample(bypass_pts[i]);

    drain_results();
    c = CFG_RESET;
    c.mode = CURVE_UNSIGNED;
    c.scale_gain = 16'sh7fff;
    c.rate_gain = 16'sh8000;
    c.trim_offset = 16'sh7fff;
    c.expo = 15'(EXPO_ONE);
    load_config(c);
    foreach (sat_pts[i]) send_sample(sat_pts[i]);

    for (int ph = 0; ph < 20; ph++) begin
      drain_results();
      load_config(pick_config());
      if (ph == 7) begin
        run_phase(15, 1'b1);
        drain_results();
        run_phase(16, 1'b1);
      end else begin
        run_phase(31, (ph < 17) && ($urandom_range(0, 3) != 0));
      end
    end

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rces_pkg.sv
rtl/rces_exp_rom.sv
rtl/rc_channel_expo_rate_shaper.sv
bench/tb_rc_channel_expo_rate_shaper.sv
